>>> rtl/stq_pkg.sv
package stq_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned ENTRY_W  = KEY_W + HANDLE_W;

  // Most expiry reports one tick may give
  localparam int unsigned MAX_RESULTS = 16;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_ADJUST = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_DUP      = 2'd3;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

endpackage

>>> rtl/stq_ram.sv
module stq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sorted_timer_queue.sv
// Channel   Direction  Handshake             Fields
// command   in         start & !busy         mode, handle, expire_time, current_time
// result    out        valid, one cycle      kind, handle_out, status, last
//
// Entries live in one RAM with registered read; each command scans the list,
// then shifts the touched run, if any, one entry per cycle.
// Reset clears the entry count and the result strobe.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_timer_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  handle,
  input  logic [31:0] expire_time,
  input  logic [31:0] current_time,
  output logic        valid,
  output logic        kind,
  output logic [7:0]  handle_out,
  output logic [1:0]  status,
  output logic        last
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = stq_pkg::ENTRY_W;
  localparam int unsigned KW = stq_pkg::KEY_W;
  localparam int unsigned HW = stq_pkg::HANDLE_W;

  typedef enum logic [2:0] {
    IDLE, SCAN, SHIFT_UP, SHIFT_DN, WRITE, REPORT
  } state_t;

  state_t state;

  logic [1:0]    mode_r;
  logic [HW-1:0] handle_r;
  logic [KW-1:0] key_r;
  logic [KW-1:0] now_r;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] lim;
  logic [CW-1:0] off;
  logic          iss;
  logic          rd_pend;
  logic [CW-1:0] rd_idx;
  logic          found;
  logic [CW-1:0] pos;
  logic          ins_set;
  logic [CW-1:0] ins;
  logic          q_set;
  logic [CW-1:0] q;
  logic          mv;
  logic          run;
  logic [CW-1:0] k;
  logic          pend_v;
  logic [HW-1:0] pend_h;
  logic          fin_wr;
  logic [AW-1:0] wa;
  logic [1:0]    st;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rd_data;
  logic [KW-1:0] e_key;
  logic [HW-1:0] e_h;
  logic [CW-1:0] dn_idx;
  logic [CW-1:0] up_idx;
  logic [CW-1:0] pos_p1;
  logic [CW-1:0] q_m1;

  assign e_key  = rd_data[EW-1:HW];
  assign e_h    = rd_data[HW-1:0];
  assign dn_idx = rd_idx - off;
  assign up_idx = rd_idx + CW'(1);
  assign pos_p1 = pos + CW'(1);
  assign q_m1   = q - CW'(1);
  assign busy   = (state != IDLE);

  always_comb begin
    we    = 1'b0;
    waddr = wa;
    wdata = {key_r, handle_r};
    case (state)
      SHIFT_DN: begin
        we    = rd_pend;
        waddr = dn_idx[AW-1:0];
        wdata = rd_data;
      end
      SHIFT_UP: begin
        we    = rd_pend;
        waddr = up_idx[AW-1:0];
        wdata = rd_data;
      end
      WRITE: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  stq_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ptr[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        IDLE: begin
          if (start) begin
            mode_r   <= mode;
            handle_r <= handle;
            key_r    <= expire_time;
            now_r    <= current_time;
            ptr      <= '0;
            rd_pend  <= 1'b0;
            found    <= 1'b0;
            ins_set  <= 1'b0;
            ins      <= count;
            q_set    <= 1'b0;
            q        <= count;
            mv       <= 1'b0;
            run      <= 1'b1;
            k        <= '0;
            pend_v   <= 1'b0;
            fin_wr   <= 1'b0;
            state    <= SCAN;
          end
        end

        SCAN: begin
          if (ptr < count) begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr;
            ptr     <= ptr + CW'(1);
          end else begin
            rd_pend <= 1'b0;
          end

          if (rd_pend) begin
            if (!found && e_h == handle_r) begin
              found <= 1'b1;
              pos   <= rd_idx;
            end
            if (!ins_set && key_r < e_key) begin
              ins_set <= 1'b1;
              ins     <= rd_idx;
            end
            if (found && rd_idx == pos_p1) begin
              mv <= (key_r >= e_key);
            end
            if (found && rd_idx > pos_p1 && !q_set && key_r < e_key) begin
              q_set <= 1'b1;
              q     <= rd_idx;
            end
            if (mode_r == stq_pkg::MODE_TICK) begin
              if (run && 32'(k) < stq_pkg::MAX_RESULTS && now_r >= e_key) begin
                if (pend_v) begin
                  valid      <= 1'b1;
                  kind       <= stq_pkg::KIND_EXPIRY;
                  handle_out <= pend_h;
                  status     <= stq_pkg::ST_OK;
                  last       <= 1'b0;
                end
                pend_v <= 1'b1;
                pend_h <= e_h;
                k      <= k + CW'(1);
              end else begin
                run <= 1'b0;
              end
            end
          end else if (ptr >= count) begin
            // Scan finished: pick the rewrite for this command
            case (mode_r)
              stq_pkg::MODE_ADD: begin
                if (found) begin
                  st    <= stq_pkg::ST_DUP;
                  state <= REPORT;
                end else if (32'(count) >= DEPTH) begin
                  st    <= stq_pkg::ST_FULL;
                  state <= REPORT;
                end else begin
                  st     <= stq_pkg::ST_OK;
                  count  <= count + CW'(1);
                  wa     <= ins[AW-1:0];
                  fin_wr <= 1'b1;
                  if (ins == count) begin
                    state <= WRITE;
                  end else begin
                    ptr   <= count - CW'(1);
                    lim   <= ins;
                    iss   <= 1'b1;
                    state <= SHIFT_UP;
                  end
                end
              end
              stq_pkg::MODE_DELETE: begin
                if (!found) begin
                  st    <= stq_pkg::ST_NOTFOUND;
                  state <= REPORT;
                end else begin
                  st    <= stq_pkg::ST_OK;
                  count <= count - CW'(1);
                  ptr   <= pos_p1;
                  lim   <= count;
                  off   <= CW'(1);
                  state <= (pos_p1 == count) ? REPORT : SHIFT_DN;
                end
              end
              stq_pkg::MODE_ADJUST: begin
                st     <= found ? stq_pkg::ST_OK : stq_pkg::ST_NOTFOUND;
                fin_wr <= found;
                if (!found) begin
                  state <= REPORT;
                end else if (!mv) begin
                  wa    <= pos[AW-1:0];
                  state <= WRITE;
                end else begin
                  // Slide the run after the entry down, drop it before q
                  wa    <= q_m1[AW-1:0];
                  ptr   <= pos_p1;
                  lim   <= q;
                  off   <= CW'(1);
                  state <= SHIFT_DN;
                end
              end
              default: begin
                if (pend_v) begin
                  valid      <= 1'b1;
                  kind       <= stq_pkg::KIND_EXPIRY;
                  handle_out <= pend_h;
                  status     <= stq_pkg::ST_OK;
                  last       <= 1'b1;
                end
                count <= count - k;
                ptr   <= k;
                lim   <= count;
                off   <= k;
                state <= (k != '0 && k != count) ? SHIFT_DN : IDLE;
              end
            endcase
          end
        end

        SHIFT_DN: begin
          if (ptr < lim) begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr;
            ptr     <= ptr + CW'(1);
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              if (fin_wr) begin
                state <= WRITE;
              end else if (mode_r == stq_pkg::MODE_TICK) begin
                state <= IDLE;
              end else begin
                state <= REPORT;
              end
            end
          end
        end

        SHIFT_UP: begin
          // Walk down from the tail so no entry is overwritten before it is read
          if (iss) begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr;
            if (ptr == lim) begin
              iss <= 1'b0;
            end else begin
              ptr <= ptr - CW'(1);
            end
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= WRITE;
            end
          end
        end

        WRITE: begin
          state <= REPORT;
        end

        REPORT: begin
          valid      <= 1'b1;
          kind       <= stq_pkg::KIND_STATUS;
          handle_out <= handle_r;
          status     <= st;
          last       <= 1'b1;
          state      <= IDLE;
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> sim/sorted_timer_queue_tb.sv
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_OPS   = 480;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4 * DEPTH + 20;
  localparam int HANDLE_POOL  = 24;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  handle;
    logic [31:0] expire_time;
    logic [31:0] current_time;
  } timer_cmd_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] handle;
    logic [1:0] status;
    logic       last;
  } timer_result_t;

  // How a directed row is checked: by the predictor, no result at all, or one typed status
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_STATUS
  } check_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  handle;
    logic [31:0] expire_time;
    logic [31:0] current_time;
    logic [4:0]  reps;
    check_e      chk;
    logic [1:0]  status;
  } timer_row_t;

  localparam int NROWS = 19;

  // Repeated rows step the handle up by one and the expiry down by 7
  localparam timer_row_t DIRECTED [NROWS] = '{
    '{MODE_TICK,   8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 5'd1,  CHK_NONE,   ST_OK},
    '{MODE_DELETE, 8'h00, 32'h0000_0000, 32'h0000_0000, 5'd1,  CHK_STATUS, ST_NOTFOUND},
    '{MODE_ADJUST, 8'hFF, 32'h1234_5678, 32'h0000_0000, 5'd1,  CHK_STATUS, ST_NOTFOUND},
    '{MODE_ADD,    8'h00, 32'h0000_0000, 32'h0000_0000, 5'd1,  CHK_STATUS, ST_OK},
    '{MODE_ADD,    8'h00, 32'd7,         32'h0000_0000, 5'd1,  CHK_STATUS, ST_DUP},
    '{MODE_ADD,    8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 5'd1,  CHK_STATUS, ST_OK},
    '{MODE_ADD,    8'h5A, 32'd100,       32'hFFFF_FFFF, 5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_ADD,    8'hA5, 32'd100,       32'h0000_0000, 5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_ADJUST, 8'h00, 32'd100,       32'h0000_0000, 5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_ADJUST, 8'hA5, 32'd1,         32'h0000_0000, 5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_TICK,   8'h00, 32'h0000_0000, 32'd0,         5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_TICK,   8'h00, 32'h0000_0000, 32'd100,       5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_ADJUST, 8'hFF, 32'd3000,      32'h0000_0000, 5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_ADD,    8'h30, 32'd3050,      32'h0000_0000, 5'd15, CHK_MODEL,  ST_OK},
    '{MODE_ADD,    8'h80, 32'd1,         32'h0000_0000, 5'd1,  CHK_STATUS, ST_FULL},
    '{MODE_ADD,    8'h30, 32'd1,         32'h0000_0000, 5'd1,  CHK_STATUS, ST_DUP},
    '{MODE_DELETE, 8'h77, 32'h0000_0000, 32'h0000_0000, 5'd1,  CHK_STATUS, ST_NOTFOUND},
    '{MODE_TICK,   8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 5'd1,  CHK_MODEL,  ST_OK},
    '{MODE_TICK,   8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 5'd1,  CHK_NONE,   ST_OK}
  };

  logic        clk;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic [1:0]  mode         = MODE_ADD;
  logic [7:0]  handle       = 8'h00;
  logic [31:0] expire_time  = 32'h0;
  logic [31:0] current_time = 32'h0;
  logic        busy;
  logic        valid;
  logic        kind;
  logic [7:0]  handle_out;
  logic [1:0]  status;
  logic        last;

  sorted_timer_queue #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .handle(handle),
    .expire_time(expire_time),
    .current_time(current_time),
    .valid(valid),
    .kind(kind),
    .handle_out(handle_out),
    .status(status),
    .last(last)
  );

  // Predicted timer list
  logic [31:0] key_list [DEPTH];
  logic [7:0]  id_list [DEPTH];
  int          live;

  timer_result_t op_reports[$];
  timer_result_t pending_results[$];

  int          mismatches;
  int          cycle_count;
  int          transfers;
  int          status_seen [4];
  int          expiries_seen;
  int          longest_burst;
  logic [31:0] wall_clock;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_slot(input logic [7:0] h);
    for (int i = 0; i < live; i++) begin
      if (id_list[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic void drop_at(input int pos);
    for (int i = pos; i + 1 < live; i++) begin
      key_list[i] = key_list[i + 1];
      id_list[i]  = id_list[i + 1];
    end
    live--;
  endfunction

  function automatic void place_at(input int pos, input logic [31:0] key, input logic [7:0] h);
    for (int i = live; i > pos; i--) begin
      key_list[i] = key_list[i - 1];
      id_list[i]  = id_list[i - 1];
    end
    key_list[pos] = key;
    id_list[pos]  = h;
    live++;
  endfunction

  function automatic void push_status(input logic [7:0] h, input logic [1:0] st);
    op_reports.push_back('{KIND_STATUS, h, st, 1'b1});
  endfunction

  function automatic void apply_timer_op(input timer_cmd_t c);
    int            p;
    int            j;
    int            n;
    timer_result_t tail;
    case (c.mode)
      MODE_ADD: begin
        if (find_slot(c.handle) >= 0) begin
          push_status(c.handle, ST_DUP);
        end else if (live >= DEPTH) begin
          push_status(c.handle, ST_FULL);
        end else begin
          j = 0;
          while (j < live && !(c.expire_time < key_list[j])) j++;
          place_at(j, c.expire_time, c.handle);
          push_status(c.handle, ST_OK);
        end
      end
      MODE_DELETE: begin
        p = find_slot(c.handle);
        if (p < 0) begin
          push_status(c.handle, ST_NOTFOUND);
        end else begin
          drop_at(p);
          push_status(c.handle, ST_OK);
        end
      end
      MODE_ADJUST: begin
        p = find_slot(c.handle);
        if (p < 0) begin
          push_status(c.handle, ST_NOTFOUND);
        end else begin
          key_list[p] = c.expire_time;
          // move only when the new key is not below the successor's
          if (p + 1 < live && !(c.expire_time < key_list[p + 1])) begin
            drop_at(p);
            j = p + 1;
            while (j < live && !(c.expire_time < key_list[j])) j++;
            place_at(j, c.expire_time, c.handle);
          end
          push_status(c.handle, ST_OK);
        end
      end
      default: begin
        n = 0;
        while (live > 0 && n < MAX_RESULTS && !(c.current_time < key_list[0])) begin
          op_reports.push_back('{KIND_EXPIRY, id_list[0], ST_OK, 1'b0});
          drop_at(0);
          n++;
        end
        if (n > 0) begin
          tail      = op_reports.pop_back();
          tail.last = 1'b1;
          op_reports.push_back(tail);
        end
      end
    endcase
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    if (mismatches < 40) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    end
    mismatches++;
  endtask

  // Hold the command until a transfer, then record what it should produce
  task automatic send_cmd(input timer_cmd_t c, input int gap, input check_e chk,
                          input logic [1:0] st);
    int burst;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= c.mode;
    handle       <= c.handle;
    expire_time  <= c.expire_time;
    current_time <= c.current_time;
    do @(posedge clk); while (busy);
    transfers++;
    op_reports.delete();
    apply_timer_op(c);
    if (chk == CHK_STATUS) begin
      op_reports.delete();
      push_status(c.handle, st);
    end else if (chk == CHK_NONE) begin
      op_reports.delete();
    end
    burst = 0;
    foreach (op_reports[i]) begin
      pending_results.push_back(op_reports[i]);
      if (op_reports[i].kind == KIND_EXPIRY) begin
        expiries_seen++;
        burst++;
      end else begin
        status_seen[op_reports[i].status]++;
      end
    end
    if (burst > longest_burst) longest_burst = burst;
  endtask

  function automatic logic [7:0] pick_handle(input bit prefer_live);
    if (prefer_live && live > 0 && $urandom_range(0, 1) == 1) begin
      return id_list[$urandom_range(0, live - 1)];
    end
    if ($urandom_range(0, 99) < 85) begin
      return 8'($urandom_range(0, HANDLE_POOL - 1) * 11);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_expiry();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return 32'h0;
    if (roll < 6) return 32'hFFFF_FFFF;
    if (roll < 10) return $urandom;
    return wall_clock + $urandom_range(0, 300);
  endfunction

  function automatic timer_cmd_t random_cmd();
    timer_cmd_t  c;
    int unsigned roll;
    c.handle       = 8'($urandom_range(0, 255));
    c.expire_time  = $urandom;
    c.current_time = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // noise: any mode with fully random fields
      c.mode = 2'($urandom_range(0, 3));
      return c;
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      c.mode        = MODE_ADD;
      c.handle      = pick_handle(1'b0);
      c.expire_time = pick_expiry();
    end else if (roll < 55) begin
      c.mode   = MODE_DELETE;
      c.handle = pick_handle(1'b1);
    end else if (roll < 72) begin
      c.mode        = MODE_ADJUST;
      c.handle      = pick_handle(1'b1);
      c.expire_time = pick_expiry();
    end else begin
      c.mode         = MODE_TICK;
      wall_clock     = wall_clock + $urandom_range(0, 80);
      c.current_time = wall_clock;
    end
    return c;
  endfunction

  initial begin
    timer_cmd_t c;
    timer_row_t row;
    int         gap;
    live          = 0;
    mismatches    = 0;
    transfers     = 0;
    expiries_seen = 0;
    longest_burst = 0;
    wall_clock    = 32'd500;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      for (int k = 0; k < row.reps; k++) begin
        c.mode         = row.mode;
        c.handle       = row.handle + 8'(k);
        c.expire_time  = row.expire_time - 32'(k * 7);
        c.current_time = row.current_time;
        send_cmd(c, $urandom_range(0, 5), row.chk, row.status);
      end
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      // every third stretch of 40 runs back to back
      gap = ((n / 40) % 3 == 2) ? 0 : $urandom_range(0, 5);
      send_cmd(random_cmd(), gap, CHK_MODEL, ST_OK);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    $display("covered %0d commands: %0d ok, %0d full, %0d not found, %0d duplicate",
             transfers, status_seen[ST_OK], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND], status_seen[ST_DUP]);
    $display("expired %0d timers, at most %0d in one tick", expiries_seen, longest_burst);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("sorted_timer_queue_tb: PASS");
    end else begin
      $display("sorted_timer_queue_tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        report("result with nothing pending, handle", handle_out, 0);
      end else begin
        want = pending_results.pop_front();
        if (kind != want.kind) report("kind", kind, want.kind);
        if (handle_out != want.handle) report("handle_out", handle_out, want.handle);
        if (status != want.status) report("status", status, want.status);
        if (last != want.last) report("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d results pending", pending_results.size());
      $display("sorted_timer_queue_tb: FAIL");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
